[rtl/hmm_forward_log_trellis_defines.svh]
// assertion macros shared by the checker
`ifndef HMM_FORWARD_LOG_TRELLIS_DEFINES_SVH
`define HMM_FORWARD_LOG_TRELLIS_DEFINES_SVH

// same-cycle implication
`define HFT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define HFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/hft_pkg.sv]
// ----------------------------------------------------------------------------
// hft_pkg
// constants, request codes and correction table generator for the
// log-space forward trellis
// ----------------------------------------------------------------------------
package hft_pkg;

  localparam int NUM_STATES   = 8;
  localparam int NUM_SYMBOLS  = 16;
  localparam int CORR_ENTRIES = 256;
  localparam int CORR_SHIFT   = 11;
  localparam int STATE_W      = 3;
  localparam int SYMBOL_W     = 4;
  localparam int ACC_W        = 36;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_TRANS = 2'd1;
  localparam logic [1:0] MODE_EMIT  = 2'd2;
  localparam logic [1:0] MODE_OBS   = 2'd3;

  localparam longint unsigned Q30_ONE      = 64'd1073741824;
  localparam longint unsigned EXP_STEP_Q30 = 64'd1040706261;

  typedef logic [16:0] corr_t;

  function automatic longint unsigned udiv(input longint unsigned a,
                                           input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[62:0], a[j]};
      if (r >= b) begin
        r = r - b;
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1+exp(-k/32)) in q16
  function automatic corr_t corr_value(input int k);
    longint unsigned e;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned p;
    longint unsigned sum;
    e = Q30_ONE;
    for (int j = 0; j < k; j++) begin
      e = (e * EXP_STEP_Q30) >> 30;
    end
    z = udiv(e << 30, (64'd2 << 30) + e);
    z2 = (z * z) >> 30;
    p = z;
    sum = z;
    for (int n = 3; n <= 21; n += 2) begin
      p = (p * z2) >> 30;
      sum = sum + udiv(p, longint'(n));
    end
    return corr_t'((64'd2 * sum + (64'd1 << 13)) >> 14);
  endfunction

endpackage

[rtl/hmm_forward_log_trellis.sv]
// ----------------------------------------------------------------------------
// hmm_forward_log_trellis
// log-space hmm forward pass with one shared add-compare-correct unit
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    mode row_index col_index load_value
//                                       symbol first
// out      out  out_valid / out_ready  state_index log_alpha last
// cfg      in   log_floor_we           log_floor_wdata
//
// a load request leaves the block idle, so loads are taken back to back
// an observation holds in_ready low until it is done: per state one read,
// one emission, NUM_STATES predecessor steps on the single
// add-compare-correct unit and one result, then one copy step
// a result that waits on out_ready stalls the next state's result
// rst is synchronous and clears control, floor and the alpha vectors
module hmm_forward_log_trellis import hft_pkg::*; #(
  parameter int CORR_ENTRIES_P = CORR_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                log_floor_we,
  input  logic signed [31:0]  log_floor_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic [2:0]          row_index,
  input  logic [3:0]          col_index,
  input  logic signed [31:0]  load_value,
  input  logic [3:0]          symbol,
  input  logic                first,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          state_index,
  output logic signed [31:0]  log_alpha,
  output logic                last
);

  localparam int CORR_IW = $clog2(CORR_ENTRIES_P);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EMIT = 3'd1;
  localparam logic [2:0] ST_EMW  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_COPY = 3'd5;

  localparam logic signed [31:0] FLOOR_RST = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(64'sd2147483647);

  logic [2:0]                 st;
  logic [STATE_W-1:0]         si;
  logic [STATE_W-1:0]         pi;
  logic [STATE_W-1:0]         qp;
  logic [SYMBOL_W-1:0]        sym_r;
  logic                       first_r;
  logic                       have;
  logic signed [31:0]         em;
  logic signed [ACC_W-1:0]    acc;
  logic signed [31:0]         log_floor;

  logic signed [31:0] start_mem [NUM_STATES];
  logic signed [31:0] trans_mem [NUM_STATES*NUM_STATES];
  logic signed [31:0] emit_mem  [NUM_STATES*NUM_SYMBOLS];
  logic signed [31:0] alpha_prev [NUM_STATES];
  logic signed [31:0] alpha_next [NUM_STATES];
  logic signed [31:0] trans_q;
  logic signed [31:0] emit_q;

  corr_t corr_tab [CORR_ENTRIES_P];

  for (genvar k = 0; k < CORR_ENTRIES_P; k++) begin : g_rom
    localparam corr_t V = corr_value(k);
    assign corr_tab[k] = V;
  end

  logic                    accept;
  logic signed [ACC_W-1:0] floor_x;
  logic signed [ACC_W-1:0] em_x;
  logic signed [ACC_W-1:0] t;
  logic signed [ACC_W-1:0] hi;
  logic [ACC_W-1:0]        d;
  logic [ACC_W-1:0]        idx;
  logic signed [ACC_W-1:0] lse;
  logic signed [ACC_W-1:0] r;
  logic signed [31:0]      r_clamp;
  logic                    out_free;

  assign in_ready = (st == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign floor_x  = ACC_W'(log_floor);
  assign em_x     = ACC_W'(em);

  always_comb begin
    t   = ACC_W'(alpha_prev[qp]) + ACC_W'(trans_q);
    hi  = (acc > t) ? acc : t;
    d   = (acc > t) ? ACC_W'(acc - t) : ACC_W'(t - acc);
    idx = (d + ACC_W'(1 << (CORR_SHIFT - 1))) >> CORR_SHIFT;
    lse = hi;
    if (idx < ACC_W'(CORR_ENTRIES_P)) begin
      lse = hi + ACC_W'(corr_tab[idx[CORR_IW-1:0]]);
    end
  end

  always_comb begin
    priority if (em_x <= floor_x) begin
      r = floor_x;
    end else if (first_r) begin
      r = ACC_W'(start_mem[si]) + em_x;
    end else if (have) begin
      r = acc + em_x;
    end else begin
      r = floor_x;
    end
    priority if (r <= floor_x) begin
      r_clamp = log_floor;
    end else if (r > OUT_MAX) begin
      r_clamp = 32'sh7fff_ffff;
    end else begin
      r_clamp = r[31:0];
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_START) begin
      start_mem[row_index] <= load_value;
    end
    if (accept && mode == MODE_TRANS && col_index < 4'(NUM_STATES)) begin
      trans_mem[{row_index, col_index[STATE_W-1:0]}] <= load_value;
    end
    if (accept && mode == MODE_EMIT) begin
      emit_mem[{row_index, col_index}] <= load_value;
    end
    trans_q <= trans_mem[{pi, si}];
    emit_q  <= emit_mem[{si, sym_r}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      si        <= '0;
      pi        <= '0;
      qp        <= '0;
      have      <= 1'b0;
      out_valid <= 1'b0;
      log_floor <= FLOOR_RST;
      for (int n = 0; n < NUM_STATES; n++) begin
        alpha_prev[n] <= FLOOR_RST;
        alpha_next[n] <= FLOOR_RST;
      end
    end else begin
      qp <= pi;
      if (log_floor_we) begin
        log_floor <= log_floor_wdata;
      end
      if (out_valid && out_ready && st != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (accept && mode == MODE_OBS) begin
            sym_r   <= symbol;
            first_r <= first;
            si      <= '0;
            pi      <= '0;
            st      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          pi   <= '0;
          have <= 1'b0;
          st   <= ST_EMW;
        end
        ST_EMW: begin
          em <= emit_q;
          pi <= pi + 1'b1;
          st <= ST_ACC;
        end
        ST_ACC: begin
          if (t > floor_x) begin
            acc  <= have ? lse : t;
            have <= 1'b1;
          end
          pi <= pi + 1'b1;
          if (qp == STATE_W'(NUM_STATES - 1)) begin
            st <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            state_index    <= si;
            log_alpha      <= r_clamp;
            last           <= (si == STATE_W'(NUM_STATES - 1));
            alpha_next[si] <= r_clamp;
            pi             <= '0;
            if (si == STATE_W'(NUM_STATES - 1)) begin
              st <= ST_COPY;
            end else begin
              si <= si + 1'b1;
              st <= ST_EMIT;
            end
          end
        end
        ST_COPY: begin
          for (int n = 0; n < NUM_STATES; n++) begin
            alpha_prev[n] <= alpha_next[n];
          end
          si <= '0;
          st <= ST_IDLE;
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/hft_checker.sv]
// ----------------------------------------------------------------------------
// hft_checker
// port-level checks for the forward trellis
// ----------------------------------------------------------------------------
`include "hmm_forward_log_trellis_defines.svh"

module hft_checker import hft_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         mode,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         state_index,
  input logic signed [31:0] log_alpha,
  input logic               last
);

  `HFT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(log_alpha))
  `HFT_ASSERT_NEXT(a_load_one_cycle, in_valid && in_ready && mode != MODE_OBS, in_ready)
  `HFT_ASSERT_NEXT(a_obs_busy, in_valid && in_ready && mode == MODE_OBS, !in_ready)
  `HFT_ASSERT_NOW(a_busy_mid, out_valid && !last, !in_ready)

endmodule

bind hmm_forward_log_trellis hft_checker u_hft_checker (.*);

[dv/tb_hmm_forward_log_trellis.sv]
// ----------------------------------------------------------------------------
// tb_hmm_forward_log_trellis
// self-checking bench for the log-space hmm forward trellis: loads random
// tables, runs observation sequences and compares every per-state forward
// value against an in-bench fixed-point predictor, over several floors
// ----------------------------------------------------------------------------
module tb_hmm_forward_log_trellis;
  import hft_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         mode;
    logic [2:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
    logic [3:0]         sym;
    logic               first;
  } request_t;

  typedef struct {
    logic [2:0]         state;
    logic signed [31:0] alpha;
    logic               last;
  } alpha_res_t;

  logic clk = 0;
  logic rst = 1;
  logic log_floor_we = 0;
  logic signed [31:0] log_floor_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] mode = '0;
  logic [2:0] row_index = '0;
  logic [3:0] col_index = '0;
  logic signed [31:0] load_value = '0;
  logic [3:0] symbol = '0;
  logic first = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [2:0] state_index;
  logic signed [31:0] log_alpha;
  logic last;

  hmm_forward_log_trellis i_dut (
    .clk(clk), .rst(rst),
    .log_floor_we(log_floor_we), .log_floor_wdata(log_floor_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .row_index(row_index), .col_index(col_index),
    .load_value(load_value), .symbol(symbol), .first(first),
    .out_valid(out_valid), .out_ready(out_ready),
    .state_index(state_index), .log_alpha(log_alpha), .last(last)
  );

  always #5 clk = ~clk;

  request_t   pending_q[$];
  alpha_res_t alpha_q[$];
  int  errors = 0;
  int  cycles = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  hold_cycles = 0;
  bit  stall_en = 1;
  bit  in_taken = 0;
  bit  out_taken = 0;

  // predictor state
  longint unsigned corr_tab[CORR_ENTRIES];
  longint floor_val;
  longint start_tab[NUM_STATES];
  longint trans_tab[NUM_STATES * NUM_STATES];
  longint emit_tab[NUM_STATES * NUM_SYMBOLS];
  longint alpha_vec[NUM_STATES];

  task automatic build_corr();
    longint unsigned e, z, z2, p, acc;
    e = Q30_ONE;
    for (int k = 0; k < CORR_ENTRIES; k++) begin
      z = (e << 30) / ((64'd2 << 30) + e);
      z2 = (z * z) >> 30;
      p = z;
      acc = z;
      for (int n = 3; n <= 21; n += 2) begin
        p = (p * z2) >> 30;
        acc += p / n;
      end
      corr_tab[k] = (2 * acc + (64'd1 << 13)) >> 14;
      e = (e * EXP_STEP_Q30) >> 30;
    end
  endtask

  function automatic longint log_sum(longint a, longint b);
    longint hi;
    longint unsigned d, idx;
    hi = a > b ? a : b;
    d = a > b ? a - b : b - a;
    idx = (d + (64'd1 << (CORR_SHIFT - 1))) >> CORR_SHIFT;
    if (idx < CORR_ENTRIES) hi += longint'(corr_tab[idx]);
    return hi;
  endfunction

  task automatic predict_forward(input request_t r);
    longint nxt[NUM_STATES];
    longint em, res, acc, t;
    bit have;
    alpha_res_t o;
    case (r.mode)
      MODE_START: start_tab[r.row] = r.value;
      MODE_TRANS: if (r.col < NUM_STATES) trans_tab[r.row * NUM_STATES + r.col] = r.value;
      MODE_EMIT:  emit_tab[r.row * NUM_SYMBOLS + r.col] = r.value;
      default: begin
        for (int i = 0; i < NUM_STATES; i++) begin
          em = emit_tab[i * NUM_SYMBOLS + r.sym];
          if (em <= floor_val) res = floor_val;
          else if (r.first) res = start_tab[i] + em;
          else begin
            have = 0;
            acc = 0;
            for (int p = 0; p < NUM_STATES; p++) begin
              t = alpha_vec[p] + trans_tab[p * NUM_STATES + i];
              if (t > floor_val) begin
                acc = have ? log_sum(acc, t) : t;
                have = 1;
              end
            end
            res = have ? acc + em : floor_val;
          end
          if (res <= floor_val) res = floor_val;
          else if (res > 64'sd2147483647) res = 64'sd2147483647;
          nxt[i] = res;
        end
        for (int i = 0; i < NUM_STATES; i++) begin
          alpha_vec[i] = nxt[i];
          o.state = 3'(i);
          o.alpha = 32'(nxt[i]);
          o.last = (i == NUM_STATES - 1);
          alpha_q.push_back(o);
        end
      end
    endcase
  endtask

  // handshakes seen at the rising edge
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
  end

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        predict_forward(pending_q.pop_front());
        in_gap <= $urandom_range(0, 4);
        in_valid <= 0;
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        else if (pending_q.size() > 0) begin
          mode <= pending_q[0].mode;
          row_index <= pending_q[0].row;
          col_index <= pending_q[0].col;
          load_value <= pending_q[0].value;
          symbol <= pending_q[0].sym;
          first <= pending_q[0].first;
          in_valid <= 1;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    int g;
    if (!rst) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 0;
      end else if (out_taken) begin
        g = stall_en ? $urandom_range(0, 4) : 0;
        out_gap <= g;
        out_ready <= (g == 0);
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= (out_gap == 1);
      end else out_ready <= 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    alpha_res_t x;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (alpha_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result state %0d alpha %0d", $time, state_index, log_alpha);
      end else begin
        x = alpha_q.pop_front();
        if (x.state !== state_index || x.alpha !== log_alpha || x.last !== last) begin
          errors++;
          $display("%0t: expected state %0d alpha %0d last %0b, got %0d %0d %0b",
                   $time, x.state, x.alpha, x.last, state_index, log_alpha, last);
        end
      end
    end
    if (cycles > 2000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_logp();
    case ($urandom_range(0, 5))
      0: return 32'sh80000000;
      1: return 0;
      2: return -$signed({1'b0, 31'($urandom_range(0, 32'h7fffffff))});
      default: return -$signed(32'($urandom_range(0, 20 << 16)));
    endcase
  endfunction

  task automatic add_req(int m, int r, int c, logic signed [31:0] v, int s, int f);
    request_t q;
    q.mode = 2'(m); q.row = 3'(r); q.col = 4'(c); q.value = v;
    q.sym = 4'(s); q.first = 1'(f);
    pending_q.push_back(q);
  endtask

  task automatic load_tables();
    for (int i = 0; i < NUM_STATES; i++) begin
      add_req(MODE_START, i, $urandom, rand_logp(), $urandom, $urandom);
      for (int j = 0; j < NUM_STATES; j++)
        add_req(MODE_TRANS, i, j, rand_logp(), $urandom, $urandom);
      for (int j = 0; j < NUM_SYMBOLS; j++)
        add_req(MODE_EMIT, i, j, rand_logp(), $urandom, $urandom);
    end
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_valid && alpha_q.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_floor(logic signed [31:0] v);
    @(negedge clk);
    log_floor_we <= 1;
    log_floor_wdata <= v;
    @(negedge clk);
    log_floor_we <= 0;
    floor_val = v;
  endtask

  initial begin
    build_corr();
    floor_val = -64'sd2147483648;
    for (int i = 0; i < NUM_STATES; i++) alpha_vec[i] = floor_val;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    load_tables();
    // observation with no first after reset, symbols 0, 3, 4, 8, 12 and 15, out-of-range loads
    add_req(MODE_OBS, 0, 0, 0, 0, 0);
    add_req(MODE_OBS, 7, 15, 32'sh80000000, 15, 1);
    add_req(MODE_TRANS, 2, 8, -100, 0, 0);
    add_req(MODE_TRANS, 7, 15, 0, 0, 0);
    add_req(MODE_OBS, 0, 0, 0, 3, 0);
    add_req(MODE_EMIT, 7, 15, 32'sh80000000, 0, 0);
    add_req(MODE_OBS, 0, 0, 0, 15, 0);
    for (int s = 0; s < NUM_SYMBOLS; s += 4) add_req(MODE_OBS, 0, 0, 0, s, s == 0);
    drain();
    // long receiver hold so the block backs up
    hold_cycles = 400;
    for (int k = 0; k < 10; k++) add_req(MODE_OBS, 0, 0, 0, $urandom, k == 0);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_floor(0);
        1: set_floor(-(40 << 16));
        2: set_floor($signed(-$urandom_range(1, 32'h7fffffff)));
        default: set_floor(32'sh80000000);
      endcase
      stall_en = (ph != 2);
      for (int k = 0; k < 30; k++)
        if ($urandom_range(0, 9) == 0)
          add_req($urandom_range(0, 2), $urandom, $urandom, rand_logp(), $urandom, $urandom);
        else
          add_req(MODE_OBS, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 5) == 0);
      drain();
    end
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
